// ----- sv/fifo_page_residency_manager_assert.svh -----
// Assertion macros for the page residency manager
`ifndef FIFO_PAGE_RESIDENCY_MANAGER_ASSERT_SVH
`define FIFO_PAGE_RESIDENCY_MANAGER_ASSERT_SVH

`ifndef SYNTH
// check outside reset
`define FPRM_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define FPRM_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPRM_CHECK(lbl, prop, msg)
`define FPRM_CHECK_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/fprm_pkg.sv -----
package fprm_pkg;

    localparam int DEF_RAM_FRAMES = 64;
    localparam int DEF_SWAP_DEPTH = 256;
    localparam int DEF_PAGE_BITS  = 16;
    localparam int DEF_OWNER_BITS = 8;

    localparam int FRAMES_CFG_W = 7;
    localparam int SLOTS_CFG_W  = 9;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_ADDR_W   = 1;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 3;
    localparam int REMOVED_W    = 7;

    localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET = 7'd64;
    localparam logic [SLOTS_CFG_W-1:0]  SLOTS_RESET  = 9'd256;

    localparam logic [CFG_ADDR_W-1:0] REG_RAM_FRAMES = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SWAP_SLOTS = 1'd1;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACCESS  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_IN_RAM    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IN_SWAP   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OOM       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EVICTED   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd7;

endpackage

// ----- sv/fifo_page_residency_manager.sv -----
// Channel   Dir  Signals                   Content (lowest bit first)
// s_*       in   tvalid tready tdata tuser request: tuser kind; tdata owner_id, page_num
// m_*       out  tvalid tready tdata       result: status, evict_valid, evict_owner,
//                                          evict_page, removed_count
// cfg_*     in   we addr wdata             0 ram_frames, 1 swap_slots
//
// Allocate into RAM writes the frame memory directly; other items may scan resident
// frames, swap slots or both, each step a read state and a check state, before the
// response; a load adds a push state and an eviction a read and a check state.
// Resident pages sit in a circular frame memory; swap entries with valid bit in a
// second memory, both single read port with registered read data.
// After reset a clearing pass over all SWAP_DEPTH swap slots runs before the first item.
// The output register holds one result; a new item is taken while it waits.
module fifo_page_residency_manager
    import fprm_pkg::*;
#(
    parameter int RAM_FRAMES = DEF_RAM_FRAMES,
    parameter int SWAP_DEPTH = DEF_SWAP_DEPTH,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int OWNER_BITS = DEF_OWNER_BITS,
    localparam int IN_W  = OWNER_BITS + PAGE_BITS,
    localparam int IN_TW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W = STATUS_W + 1 + OWNER_BITS + PAGE_BITS + REMOVED_W,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TW-1:0]      s_tdata,   // owner_id, page_num
    input  logic [KIND_W-1:0]     s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_TW-1:0]     m_tdata,   // status, evict_valid, evict_owner,
                                             // evict_page, removed_count
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "fifo_page_residency_manager_assert.svh"

    localparam int FA   = $clog2(RAM_FRAMES);
    localparam int CW   = $clog2(RAM_FRAMES + 1);
    localparam int SA   = $clog2(SWAP_DEPTH);
    localparam int UW   = $clog2(SWAP_DEPTH + 1);
    localparam int FE_W = OWNER_BITS + PAGE_BITS;
    localparam int SE_W = 1 + FE_W;

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_HRD   = 14'b00000000000100,
        S_HCHK  = 14'b00000000001000,
        S_SLRD  = 14'b00000000010000,
        S_SLCHK = 14'b00000000100000,
        S_EVRD  = 14'b00000001000000,
        S_EVCHK = 14'b00000010000000,
        S_STRD  = 14'b00000100000000,
        S_STCHK = 14'b00001000000000,
        S_RRD   = 14'b00010000000000,
        S_RCHK  = 14'b00100000000000,
        S_PUSH  = 14'b01000000000000,
        S_RESP  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [FRAMES_CFG_W-1:0] ram_frames_reg;
    logic [SLOTS_CFG_W-1:0]  swap_slots_reg;
    logic [FA-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [UW-1:0] used_reg, used_next;
    logic [FA-1:0] rd_reg, rd_next;
    logic [FA-1:0] wr_reg, wr_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [CW-1:0] removed_reg, removed_next;
    logic [SA-1:0] sidx_reg, sidx_next;
    logic          out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [OWNER_BITS-1:0] ld_owner_reg, ld_owner_next;
    logic [OWNER_BITS-1:0] ev_owner_reg, ev_owner_next;
    logic [PAGE_BITS-1:0]  ev_page_reg, ev_page_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic [CW-1:0] flim;
    logic [UW-1:0] slim;
    logic [CW:0]   tsum;
    logic [FA-1:0] tail;
    logic [OWNER_BITS-1:0] in_owner;
    logic [PAGE_BITS-1:0]  in_page;
    logic [OWNER_BITS-1:0] st_owner;
    logic [PAGE_BITS-1:0]  st_page;

    logic            f_we;
    logic [FA-1:0]   f_waddr;
    logic [FE_W-1:0] f_wdata;
    logic [FE_W-1:0] f_rdata;
    logic [OWNER_BITS-1:0] f_owner;
    logic [PAGE_BITS-1:0]  f_page;

    logic            sw_we;
    logic [SE_W-1:0] sw_wdata;
    logic [SE_W-1:0] sw_rdata;
    logic            sw_valid;
    logic [OWNER_BITS-1:0] sw_owner;
    logic [PAGE_BITS-1:0]  sw_page;
    logic            sidx_last;

    function automatic logic [FA-1:0] fnext(input logic [FA-1:0] p);
        return (p == FA'(RAM_FRAMES - 1)) ? '0 : p + 1'b1;
    endfunction

    fprm_ram #(.WIDTH(FE_W), .DEPTH(RAM_FRAMES)) u_frame_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (rd_reg),
        .rdata (f_rdata)
    );

    fprm_ram #(.WIDTH(SE_W), .DEPTH(SWAP_DEPTH)) u_swap_ram (
        .clk   (clk),
        .we    (sw_we),
        .waddr (sidx_reg),
        .wdata (sw_wdata),
        .raddr (sidx_reg),
        .rdata (sw_rdata)
    );

    assign in_owner = s_tdata[OWNER_BITS-1:0];
    assign in_page  = s_tdata[IN_W-1:OWNER_BITS];
    assign f_owner  = f_rdata[FE_W-1:PAGE_BITS];
    assign f_page   = f_rdata[PAGE_BITS-1:0];
    assign sw_valid = sw_rdata[SE_W-1];
    assign sw_owner = sw_rdata[FE_W-1:PAGE_BITS];
    assign sw_page  = sw_rdata[PAGE_BITS-1:0];
    assign sidx_last = (sidx_reg == SA'(SWAP_DEPTH - 1));
    assign st_owner = (kind_reg == KIND_ALLOC) ? owner_reg : ev_owner_reg;
    assign st_page  = (kind_reg == KIND_ALLOC) ? page_reg : ev_page_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(out_data_reg);

    always_comb
    begin
        if (ram_frames_reg == '0)
        begin
            flim = CW'(1);
        end
        else if (int'(ram_frames_reg) > RAM_FRAMES)
        begin
            flim = CW'(RAM_FRAMES);
        end
        else
        begin
            flim = CW'(ram_frames_reg);
        end
        if (int'(swap_slots_reg) > SWAP_DEPTH)
        begin
            slim = UW'(SWAP_DEPTH);
        end
        else
        begin
            slim = UW'(swap_slots_reg);
        end
        tsum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        if (tsum >= (CW+1)'(RAM_FRAMES))
        begin
            tail = FA'(tsum - (CW+1)'(RAM_FRAMES));
        end
        else
        begin
            tail = FA'(tsum);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        removed_next   = removed_reg;
        sidx_next      = sidx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        kind_next      = kind_reg;
        owner_next     = owner_reg;
        page_next      = page_reg;
        ld_owner_next  = ld_owner_reg;
        ev_owner_next  = ev_owner_reg;
        ev_page_next   = ev_page_reg;
        ev_valid_next  = ev_valid_reg;
        status_next    = status_reg;
        f_we     = 1'b0;
        f_waddr  = tail;
        f_wdata  = {ld_owner_reg, page_reg};
        sw_we    = 1'b0;
        sw_wdata = '0;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                sw_we = 1'b1;
                if (sidx_last)
                begin
                    sidx_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sidx_next = sidx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next     = s_tuser;
                    owner_next    = in_owner;
                    page_next     = in_page;
                    ev_valid_next = 1'b0;
                    ev_owner_next = '0;
                    ev_page_next  = '0;
                    removed_next  = '0;
                    kept_next     = '0;
                    idx_next      = '0;
                    rd_next       = head_reg;
                    wr_next       = head_reg;
                    sidx_next     = '0;
                    case (s_tuser)
                        KIND_ALLOC:
                        begin
                            if (count_reg < flim)
                            begin
                                f_we        = 1'b1;
                                f_wdata     = {in_owner, in_page};
                                count_next  = count_reg + 1'b1;
                                status_next = ST_IN_RAM;
                                state_next  = S_RESP;
                            end
                            else if (used_reg < slim)
                            begin
                                state_next = S_STRD;
                            end
                            else
                            begin
                                status_next = ST_OOM;
                                state_next  = S_RESP;
                            end
                        end
                        KIND_RELEASE:
                        begin
                            status_next = ST_RELEASED;
                            state_next  = (count_reg == '0) ? S_RESP : S_RRD;
                        end
                        KIND_ACCESS:
                        begin
                            state_next = (count_reg == '0) ? S_SLRD : S_HRD;
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end
            S_HRD:
            begin
                state_next = S_HCHK;
            end
            S_HCHK:
            begin
                if (f_page == page_reg)
                begin
                    status_next = ST_HIT;
                    state_next  = S_RESP;
                end
                else
                begin
                    rd_next  = fnext(rd_reg);
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg + 1'b1 == count_reg) ? S_SLRD : S_HRD;
                end
            end
            S_SLRD:
            begin
                state_next = S_SLCHK;
            end
            S_SLCHK:
            begin
                if (sw_valid && (sw_page == page_reg))
                begin
                    ld_owner_next = sw_owner;
                    sw_we         = 1'b1;
                    used_next     = used_reg - 1'b1;
                    if (count_reg >= flim)
                    begin
                        rd_next    = head_reg;
                        state_next = S_EVRD;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else if (sidx_last)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    sidx_next  = sidx_reg + 1'b1;
                    state_next = S_SLRD;
                end
            end
            S_EVRD:
            begin
                state_next = S_EVCHK;
            end
            S_EVCHK:
            begin
                ev_valid_next = 1'b1;
                ev_owner_next = f_owner;
                ev_page_next  = f_page;
                head_next     = fnext(head_reg);
                count_next    = count_reg - 1'b1;
                if (used_reg < slim)
                begin
                    sidx_next  = '0;
                    state_next = S_STRD;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_STRD:
            begin
                state_next = S_STCHK;
            end
            S_STCHK:
            begin
                if (!sw_valid)
                begin
                    sw_we     = 1'b1;
                    sw_wdata  = {1'b1, st_owner, st_page};
                    used_next = used_reg + 1'b1;
                    if (kind_reg == KIND_ALLOC)
                    begin
                        status_next = ST_IN_SWAP;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else if (sidx_last)
                begin
                    if (kind_reg == KIND_ALLOC)
                    begin
                        status_next = ST_OOM;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else
                begin
                    sidx_next  = sidx_reg + 1'b1;
                    state_next = S_STRD;
                end
            end
            S_RRD:
            begin
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                rd_next  = fnext(rd_reg);
                idx_next = idx_reg + 1'b1;
                if (f_owner != owner_reg)
                begin
                    f_we      = 1'b1;
                    f_waddr   = wr_reg;
                    f_wdata   = f_rdata;
                    wr_next   = fnext(wr_reg);
                    kept_next = kept_reg + 1'b1;
                end
                else
                begin
                    removed_next = removed_reg + 1'b1;
                end
                if (idx_reg + 1'b1 == count_reg)
                begin
                    count_next = kept_next;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_RRD;
                end
            end
            S_PUSH:
            begin
                f_we        = 1'b1;
                count_next  = count_reg + 1'b1;
                status_next = ev_valid_reg ? ST_EVICTED : ST_LOADED;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {REMOVED_W'(removed_reg), ev_page_reg, ev_owner_reg,
                                      ev_valid_reg, status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ram_frames_reg <= FRAMES_RESET;
            swap_slots_reg <= SLOTS_RESET;
            head_reg       <= '0;
            count_reg      <= '0;
            used_reg       <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            idx_reg        <= '0;
            kept_reg       <= '0;
            removed_reg    <= '0;
            sidx_reg       <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_ALLOC;
            ev_valid_reg   <= 1'b0;
            status_reg     <= ST_NOT_FOUND;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            idx_reg       <= idx_next;
            kept_reg      <= kept_next;
            removed_reg   <= removed_next;
            sidx_reg      <= sidx_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            ev_valid_reg  <= ev_valid_next;
            status_reg    <= status_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_RAM_FRAMES: ram_frames_reg <= cfg_wdata[FRAMES_CFG_W-1:0];
                    REG_SWAP_SLOTS: swap_slots_reg <= cfg_wdata[SLOTS_CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        owner_reg    <= owner_next;
        page_reg     <= page_next;
        ld_owner_reg <= ld_owner_next;
        ev_owner_reg <= ev_owner_next;
        ev_page_reg  <= ev_page_next;
    end

    `FPRM_CHECK_ALWAYS(a_count_bound, count_reg <= CW'(RAM_FRAMES), "resident count above frames")
    `FPRM_CHECK(a_used_bound, used_reg <= UW'(SWAP_DEPTH), "swap use above depth")
    `FPRM_CHECK(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")
    `FPRM_CHECK(a_evict_flag, out_valid_reg |-> (out_data_reg[STATUS_W] == (out_data_reg[STATUS_W-1:0] == ST_EVICTED)), "evict flag mismatch")

endmodule

// ----- sv/fprm_ram.sv -----
module fprm_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import fprm_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [15:0] page;
        logic [7:0]  owner;
    } page_entry_t;

    typedef struct packed {
        logic [REMOVED_W-1:0] removed;
        logic [15:0]          ev_page;
        logic [7:0]           ev_owner;
        logic                 ev_valid;
        logic [STATUS_W-1:0]  status;
    } outcome_t;

    class page_scoreboard;
        logic [FRAMES_CFG_W-1:0] ram_frames;
        logic [SLOTS_CFG_W-1:0]  swap_slots;
        page_entry_t resident[$];
        page_entry_t swap_entry[DEF_SWAP_DEPTH];
        bit          swap_valid[DEF_SWAP_DEPTH];
        int          swap_used;
        outcome_t    pending[$];
        int          errors;
        int          results;
        int          status_seen[8];

        function new();
            ram_frames = FRAMES_RESET;
            swap_slots = SLOTS_RESET;
            swap_used = 0;
            errors = 0;
            results = 0;
            foreach (swap_valid[i]) swap_valid[i] = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_RAM_FRAMES) ram_frames = val[FRAMES_CFG_W-1:0];
            else if (idx == REG_SWAP_SLOTS) swap_slots = val;
        endfunction

        function int frame_cap();
            if (ram_frames == 0) return 1;
            if (ram_frames > DEF_RAM_FRAMES) return DEF_RAM_FRAMES;
            return ram_frames;
        endfunction

        function bit swap_put(page_entry_t e);
            int lim;
            lim = (swap_slots > DEF_SWAP_DEPTH) ? DEF_SWAP_DEPTH : swap_slots;
            if (swap_used >= lim) return 0;
            for (int i = 0; i < DEF_SWAP_DEPTH; i++)
            begin
                if (!swap_valid[i])
                begin
                    swap_valid[i] = 1;
                    swap_entry[i] = e;
                    swap_used++;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [7:0] owner,
                                   logic [15:0] page);
            outcome_t o;
            page_entry_t e;
            int slot;
            bit hit;
            o = '0;
            o.status = ST_NOT_FOUND;
            e.page = page;
            e.owner = owner;
            if (kind == KIND_ALLOC)
            begin
                if (resident.size() < frame_cap())
                begin
                    resident.insert(resident.size(), e);
                    o.status = ST_IN_RAM;
                end
                else if (swap_put(e)) o.status = ST_IN_SWAP;
                else o.status = ST_OOM;
            end
            else if (kind == KIND_RELEASE)
            begin
                for (int i = resident.size() - 1; i >= 0; i--)
                begin
                    if (resident[i].owner == owner)
                    begin
                        resident.delete(i);
                        o.removed++;
                    end
                end
                o.status = ST_RELEASED;
            end
            else if (kind == KIND_ACCESS)
            begin
                hit = 0;
                foreach (resident[i]) if (resident[i].page == page) hit = 1;
                if (hit) o.status = ST_HIT;
                else
                begin
                    slot = -1;
                    for (int i = 0; i < DEF_SWAP_DEPTH && slot < 0; i++)
                        if (swap_valid[i] && swap_entry[i].page == page) slot = i;
                    if (slot >= 0)
                    begin
                        e.owner = swap_entry[slot].owner;
                        swap_valid[slot] = 0;
                        swap_used--;
                        if (resident.size() >= frame_cap() && resident.size() > 0)
                        begin
                            o.ev_valid = 1;
                            o.ev_page = resident[0].page;
                            o.ev_owner = resident[0].owner;
                            void'(swap_put(resident.pop_front()));
                            o.status = ST_EVICTED;
                        end
                        else o.status = ST_LOADED;
                        if (resident.size() < DEF_RAM_FRAMES)
                            resident.insert(resident.size(), e);
                    end
                end
            end
            pending.insert(pending.size(), o);
        endfunction

        function void check_result(logic [39:0] data);
            outcome_t got;
            outcome_t exp;
            got = data[$bits(outcome_t)-1:0];
            results++;
            if (pending.size() == 0)
            begin
                $error("unexpected result item %h", data);
                errors++;
                return;
            end
            exp = pending.pop_front();
            status_seen[got.status]++;
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.ev_valid !== exp.ev_valid)
            begin
                $error("evict_valid: expected %0d, got %0d", exp.ev_valid, got.ev_valid);
                errors++;
            end
            if (got.ev_owner !== exp.ev_owner)
            begin
                $error("evict_owner: expected %h, got %h", exp.ev_owner, got.ev_owner);
                errors++;
            end
            if (got.ev_page !== exp.ev_page)
            begin
                $error("evict_page: expected %h, got %h", exp.ev_page, got.ev_page);
                errors++;
            end
            if (got.removed !== exp.removed)
            begin
                $error("removed_count: expected %0d, got %0d", exp.removed, got.removed);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;   // owner_id, page_num
    logic [KIND_W-1:0]     s_tuser;   // kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;   // status, evict_valid, evict_owner, evict_page,
                                      // removed_count
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    page_scoreboard pages;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  cycles;

    fifo_page_residency_manager dut (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) pages.check_result(m_tdata);

    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
            end
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(logic [KIND_W-1:0] kind, logic [7:0] owner,
                                logic [15:0] page);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 0;
            @(negedge clk);
        end
        s_tvalid = 1;
        s_tuser = kind;
        s_tdata = {page, owner};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pages.note_request(kind, owner, page);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 0;
        while (pages.pending.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1;
        cfg_addr = idx;
        cfg_wdata = val;
        pages.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic random_request();
        logic [KIND_W-1:0] kind;
        logic [7:0]  owner;
        logic [15:0] page;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) kind = KIND_ALLOC;
        else if (pick < 50) kind = KIND_RELEASE;
        else if (pick < 95) kind = KIND_ACCESS;
        else kind = KIND_SPARE;
        owner = ($urandom_range(99) < 85) ? 8'($urandom_range(5)) : 8'($urandom_range(255));
        page = ($urandom_range(99) < 80) ? 16'($urandom_range(23))
                                         : 16'($urandom_range(65535));
        send_request(kind, owner, page);
    endtask

    initial
    begin
        int frames_set[6];
        int slots_set[6];
        pages = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        hold_req = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_request(KIND_ALLOC, 8'h00, 16'h0000);
        send_request(KIND_ALLOC, 8'hFF, 16'hFFFF);
        send_request(KIND_ALLOC, 8'h55, 16'hAAAA);
        send_request(KIND_ALLOC, 8'hAA, 16'h5555);
        send_request(KIND_ACCESS, 8'h00, 16'hFFFF);
        send_request(KIND_ACCESS, 8'h00, 16'h1234);
        send_request(KIND_SPARE, 8'hFF, 16'hFFFF);
        send_request(KIND_RELEASE, 8'hFF, 16'h0000);
        send_request(KIND_RELEASE, 8'h77, 16'h0000);
        drain();
        write_reg(REG_RAM_FRAMES, 9'd1);
        write_reg(REG_SWAP_SLOTS, 9'd2);
        send_request(KIND_ALLOC, 8'h01, 16'h0005);
        send_request(KIND_ALLOC, 8'h02, 16'h0006);
        send_request(KIND_ALLOC, 8'h03, 16'h0007);
        send_request(KIND_ACCESS, 8'h00, 16'h0005);
        send_request(KIND_ACCESS, 8'h00, 16'h0006);
        send_request(KIND_ALLOC, 8'h03, 16'h0006);
        send_request(KIND_ACCESS, 8'h00, 16'h0006);
        drain();
        write_reg(REG_RAM_FRAMES, 9'd0);
        write_reg(REG_SWAP_SLOTS, 9'd0);
        send_request(KIND_ACCESS, 8'h00, 16'hAAAA);
        send_request(KIND_ALLOC, 8'h09, 16'h0009);
        send_request(KIND_RELEASE, 8'h01, 16'h0000);
        send_request(KIND_RELEASE, 8'h02, 16'h0000);
        drain();

        frames_set = '{127, 1, 4, 0, 2, 64};
        slots_set = '{511, 0, 3, 300, 1, 8};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_RAM_FRAMES, CFG_DATA_W'(frames_set[ph]));
            write_reg(REG_SWAP_SLOTS, CFG_DATA_W'(slots_set[ph]));
            for (int n = 0; n < 150; n++)
            begin
                if (ph < 2)
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 63;
                end
                else if (ph < 4)
                begin
                    send_idle_pct = 63;
                    recv_idle_pct = 36;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if (n == 40) hold_req = 1;
                if (n == 90) drain();
                random_request();
            end
            drain();
        end

        $display("Covered %0d results over 9 register settings, with stalls and hold-offs.",
                 pages.results);
        $display("Status counts 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 pages.status_seen[0], pages.status_seen[1], pages.status_seen[2],
                 pages.status_seen[3], pages.status_seen[4], pages.status_seen[5],
                 pages.status_seen[6], pages.status_seen[7]);
        if (pages.errors == 0 && pages.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
